// ===== rtl/spotlight_falloff_intensity_unit_defines.svh =====
// Assertion macros for the spotlight falloff intensity unit.
// Used by the checker file only; needs clk and rst_n in the including scope.
`ifndef SPOTLIGHT_FALLOFF_INTENSITY_UNIT_DEFINES_SVH
`define SPOTLIGHT_FALLOFF_INTENSITY_UNIT_DEFINES_SVH

// same-cycle implication
`define SFI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked a fixed number of cycles later
`define SFI_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ===== rtl/sfi_pkg.sv =====
// Shared widths, types, register codes and the shape table for the spotlight unit.
// No dependencies; every module imports it.
package sfi_pkg;

  localparam int PT_W     = 16;  // Q8.8 coordinate
  localparam int E_W      = 16;  // Q1.14 direction component
  localparam int CFG_W    = 48;
  localparam int CS_W     = 16;  // Q1.14 cosine register
  localparam int EXP_W    = 5;
  localparam int D_W      = 17;
  localparam int SQ_W     = 32;
  localparam int PR_W     = 33;
  localparam int SUM_W    = 34;
  localparam int DOT_W    = 34;
  localparam int MAG_W    = 33;
  localparam int SQ_FRAC  = 16;
  localparam int LEN_W    = 25;
  localparam int RM_W     = 51;
  localparam int COS_SHIFT = 8;
  localparam int NC_W     = MAG_W + COS_SHIFT;
  localparam int CQ_W     = 17;
  localparam int C_W      = 18;
  localparam int UD_W     = 16;
  localparam int SHAPE_DEPTH = 256;
  localparam int IQ_W     = $clog2(SHAPE_DEPTH + 1);
  localparam int DVD_W    = UD_W + $clog2(SHAPE_DEPTH);
  localparam int SH_W     = 17;
  localparam int NUM_W    = 48;
  localparam int DQ_W     = 32;
  localparam int OUT_W    = 32;
  localparam int CIDX_W   = 3;

  // register count along the pipe, input beat to result strobe
  localparam int LATENCY  = 3 + LEN_W + CQ_W + (3 + IQ_W) + (2 + DQ_W);

  localparam logic [SH_W-1:0] ONE_Q16 = SH_W'(65536);

  typedef enum logic [CIDX_W-1:0] {
    CFG_LIGHT_POSITION  = 3'd0,
    CFG_LIGHT_DIRECTION = 3'd1,
    CFG_COS_CONE        = 3'd2,
    CFG_COS_OUTER       = 3'd3,
    CFG_EXPOSURE        = 3'd4,
    CFG_DECAY_CONSTANT  = 3'd5
  } cfg_idx_t;

  // geometry of one beat after the front end
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [MAG_W-1:0] mag;
    logic             neg;
  } geo_t;

  // cosine quotient with sign
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CQ_W-1:0]  quo;
    logic             neg;
  } cos_t;

  // shaped spot value
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SH_W-1:0]  sh;
  } shp_t;

  // shape table: 0.5 - 0.5cos(pi*i/DEPTH) in Q16, Taylor series in Q30
  typedef logic [SH_W-1:0] shape_rom_t [SHAPE_DEPTH+1];
  typedef longint unsigned taylor_t [8];

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam taylor_t TAYLOR_DIV = '{64'd2, 64'd12, 64'd30, 64'd56,
                                     64'd90, 64'd132, 64'd182, 64'd240};

  function automatic logic [SH_W-1:0] shape_low(int unsigned i);
    longint unsigned u;
    longint unsigned u2;
    longint unsigned term;
    longint          cosv;
    longint          s;
    u    = (PI_Q30 * longint'(i) + SHAPE_DEPTH / 2) / SHAPE_DEPTH;
    u2   = (u * u) >> 30;
    term = ONE_Q30;
    cosv = longint'(ONE_Q30);
    for (int k = 0; k < 8; k++) begin
      term = ((term * u2) >> 30) / TAYLOR_DIV[k];
      if (k % 2 == 0) cosv = cosv - longint'(term);
      else            cosv = cosv + longint'(term);
    end
    s = (longint'(ONE_Q30) - cosv) / 2;
    if (s < 0) s = 0;
    return SH_W'((s + 8192) >>> 14);
  endfunction

  function automatic shape_rom_t build_shape_rom();
    shape_rom_t rom;
    for (int i = 0; i <= SHAPE_DEPTH; i++) begin
      if (2 * i <= SHAPE_DEPTH) rom[i] = shape_low(i);
      else                      rom[i] = '0;
    end
    for (int i = 0; i <= SHAPE_DEPTH; i++) begin
      if (2 * i > SHAPE_DEPTH) rom[i] = ONE_Q16 - rom[SHAPE_DEPTH - i];
    end
    return rom;
  endfunction

  localparam shape_rom_t SHAPE_ROM = build_shape_rom();

endpackage

// ===== rtl/spotlight_falloff_intensity_unit.sv =====
// Spot light intensity unit: one query point per clock, with a result strobe for each.
// Latency is set by the bit-per-stage square root (25), cosine divide (17), table index
// divide (9) and falloff divide (32) plus 8 stages of arithmetic and registers.
// Throughput: one beat every cycle; busy is never raised.
// Synchronous active-low reset clears the pipeline valids and loads register defaults.
// Depends on sfi_pkg and the sfi_front/sqrt/cdiv/shape/scale modules.
module spotlight_falloff_intensity_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [sfi_pkg::PT_W-1:0]   in_point_x,
  input  logic signed [sfi_pkg::PT_W-1:0]   in_point_y,
  input  logic signed [sfi_pkg::PT_W-1:0]   in_point_z,
  output logic                              out_valid,
  output logic [sfi_pkg::OUT_W-1:0]         out_intensity,
  output logic                              out_saturated,
  output logic                              out_zero_distance,
  input  logic                              cfg_wr_en,
  input  logic [sfi_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [sfi_pkg::CFG_W-1:0]         cfg_data
);
  import sfi_pkg::*;

  logic [CFG_W-1:0]        light_position_r, light_direction_r;
  logic signed [CS_W-1:0]  cos_cone_r, cos_outer_r;
  logic [EXP_W-1:0]        exposure_r;
  logic                    decay_constant_r;

  logic accept;
  logic fr_vld, sq_vld, cd_vld, sh_vld;
  geo_t fr_geo, sq_geo;
  logic [LEN_W-1:0] sq_len;
  cos_t cd_cos;
  shp_t sh_shp;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_position_r  <= '0;
      light_direction_r <= CFG_W'(16384);
      cos_cone_r        <= CS_W'(16384);
      cos_outer_r       <= CS_W'(16384);
      exposure_r        <= '0;
      decay_constant_r  <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LIGHT_POSITION:  light_position_r  <= cfg_data;
        CFG_LIGHT_DIRECTION: light_direction_r <= cfg_data;
        CFG_COS_CONE:        cos_cone_r        <= cfg_data[CS_W-1:0];
        CFG_COS_OUTER:       cos_outer_r       <= cfg_data[CS_W-1:0];
        CFG_EXPOSURE:        exposure_r        <= cfg_data[EXP_W-1:0];
        CFG_DECAY_CONSTANT:  decay_constant_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sfi_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .in_x    (in_point_x),
    .in_y    (in_point_y),
    .in_z    (in_point_z),
    .cfg_pos (light_position_r),
    .cfg_dir (light_direction_r),
    .out_vld (fr_vld),
    .out_geo (fr_geo)
  );

  sfi_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (fr_vld),
    .in_geo  (fr_geo),
    .out_vld (sq_vld),
    .out_geo (sq_geo),
    .out_len (sq_len)
  );

  sfi_cdiv u_cdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sq_vld),
    .in_geo  (sq_geo),
    .in_len  (sq_len),
    .out_vld (cd_vld),
    .out_cos (cd_cos)
  );

  sfi_shape u_shape (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_vld        (cd_vld),
    .in_cos        (cd_cos),
    .cfg_cos_cone  (cos_cone_r),
    .cfg_cos_outer (cos_outer_r),
    .out_vld       (sh_vld),
    .out_shp       (sh_shp)
  );

  sfi_scale u_scale (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_vld             (sh_vld),
    .in_shp             (sh_shp),
    .cfg_exposure       (exposure_r),
    .cfg_decay_constant (decay_constant_r),
    .out_vld            (out_valid),
    .out_intensity      (out_intensity),
    .out_saturated      (out_saturated),
    .out_zero_distance  (out_zero_distance)
  );

endmodule

// ===== rtl/sfi_front.sv =====
// Front end: offset from the light, squared distance and dot with the direction.
// Depends on sfi_pkg. Three register stages.
module sfi_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic signed [sfi_pkg::PT_W-1:0] in_x,
  input  logic signed [sfi_pkg::PT_W-1:0] in_y,
  input  logic signed [sfi_pkg::PT_W-1:0] in_z,
  input  logic [sfi_pkg::CFG_W-1:0]  cfg_pos,
  input  logic [sfi_pkg::CFG_W-1:0]  cfg_dir,
  output logic                       out_vld,
  output sfi_pkg::geo_t              out_geo
);
  import sfi_pkg::*;

  logic signed [PT_W-1:0] pt_c  [3];
  logic signed [PT_W-1:0] pos_c [3];
  logic signed [E_W-1:0]  dir_c [3];

  logic                   vld1_r, vld2_r, vld3_r;
  logic signed [D_W-1:0]  d_r   [3];
  logic signed [D_W-1:0]  d_nxt [3];
  logic [SQ_W-1:0]        sq_r  [3];
  logic [SQ_W-1:0]        sq_nxt [3];
  logic signed [PR_W-1:0] pr_r  [3];
  logic signed [PR_W-1:0] pr_nxt [3];
  logic signed [2*D_W-1:0] sq_full [3];
  logic signed [DOT_W-1:0] dot_c;
  geo_t                   geo_r, geo_nxt;

  assign pt_c[0] = in_x;
  assign pt_c[1] = in_y;
  assign pt_c[2] = in_z;

  // unpack position and direction fields
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_c[i] = cfg_pos[PT_W*i +: PT_W];
      dir_c[i] = cfg_dir[E_W*i +: E_W];
    end
  end

  // stage 1: offset
  always_comb begin
    for (int i = 0; i < 3; i++) d_nxt[i] = D_W'(pt_c[i]) - D_W'(pos_c[i]);
  end

  // stage 2: squares and direction products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_full[i] = d_r[i] * d_r[i];
      sq_nxt[i]  = SQ_W'($unsigned(sq_full[i]));
      pr_nxt[i]  = PR_W'(d_r[i]) * PR_W'(dir_c[i]);
    end
  end

  // stage 3: sums and dot magnitude
  always_comb begin
    dot_c = DOT_W'(pr_r[0]) + DOT_W'(pr_r[1]) + DOT_W'(pr_r[2]);
    geo_nxt.sum = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    geo_nxt.neg = dot_c[DOT_W-1];
    geo_nxt.mag = dot_c[DOT_W-1] ? MAG_W'(-dot_c) : MAG_W'(dot_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    d_r   <= d_nxt;
    sq_r  <= sq_nxt;
    pr_r  <= pr_nxt;
    geo_r <= geo_nxt;
  end

  assign out_vld = vld3_r;
  assign out_geo = geo_r;

endmodule

// ===== rtl/sfi_sqrt.sv =====
// Pipelined square root of the squared distance, one result bit per stage.
// Depends on sfi_pkg. LEN_W register stages.
module sfi_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  sfi_pkg::geo_t             in_geo,
  output logic                      out_vld,
  output sfi_pkg::geo_t             out_geo,
  output logic [sfi_pkg::LEN_W-1:0] out_len
);
  import sfi_pkg::*;

  logic             vld_r  [LEN_W];
  geo_t             geo_r  [LEN_W];
  logic [RM_W-1:0]  rem_r  [LEN_W];
  logic [LEN_W-1:0] root_r [LEN_W];

  for (genvar s = 0; s < LEN_W; s++) begin : g_stg
    localparam int B = LEN_W - 1 - s;
    logic             vld_in;
    geo_t             geo_in;
    logic [RM_W-1:0]  rem_in, test, rem_nxt;
    logic [LEN_W-1:0] root_in, root_nxt;

    if (s == 0) begin : g_head
      assign vld_in  = in_vld;
      assign geo_in  = in_geo;
      assign rem_in  = RM_W'({in_geo.sum, {SQ_FRAC{1'b0}}});
      assign root_in = '0;
    end else begin : g_body
      assign vld_in  = vld_r[s-1];
      assign geo_in  = geo_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
    end

    // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    assign test = (RM_W'(root_in) << (B + 1)) + (RM_W'(1) << (2 * B));

    always_comb begin
      if (rem_in >= test) begin
        rem_nxt  = rem_in - test;
        root_nxt = root_in | (LEN_W'(1) << B);
      end else begin
        rem_nxt  = rem_in;
        root_nxt = root_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[s] <= 1'b0;
      else        vld_r[s] <= vld_in;
    end

    always_ff @(posedge clk) begin
      geo_r[s]  <= geo_in;
      rem_r[s]  <= rem_nxt;
      root_r[s] <= root_nxt;
    end
  end

  assign out_vld = vld_r[LEN_W-1];
  assign out_geo = geo_r[LEN_W-1];
  assign out_len = root_r[LEN_W-1];

endmodule

// ===== rtl/sfi_cdiv.sv =====
// Pipelined divider for the angle cosine: |dot| * 2^8 / |d|, one quotient bit per stage.
// Depends on sfi_pkg. CQ_W register stages.
module sfi_cdiv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  sfi_pkg::geo_t             in_geo,
  input  logic [sfi_pkg::LEN_W-1:0] in_len,
  output logic                      out_vld,
  output sfi_pkg::cos_t             out_cos
);
  import sfi_pkg::*;

  logic             vld_r [CQ_W];
  geo_t             geo_r [CQ_W];
  logic [LEN_W-1:0] len_r [CQ_W];
  logic [LEN_W-1:0] rem_r [CQ_W];
  logic [CQ_W-1:0]  quo_r [CQ_W];

  for (genvar s = 0; s < CQ_W; s++) begin : g_stg
    localparam int I = CQ_W - 1 - s;
    logic             vld_in;
    geo_t             geo_in;
    logic [LEN_W-1:0] len_in, rem_in, rem_nxt;
    logic [CQ_W-1:0]  quo_in, quo_nxt;
    logic [NC_W-1:0]  dvd;
    logic [LEN_W:0]   r2;

    if (s == 0) begin : g_head
      assign vld_in = in_vld;
      assign geo_in = in_geo;
      assign len_in = in_len;
      assign rem_in = LEN_W'(NC_W'({in_geo.mag, {COS_SHIFT{1'b0}}}) >> CQ_W);
      assign quo_in = '0;
    end else begin : g_body
      assign vld_in = vld_r[s-1];
      assign geo_in = geo_r[s-1];
      assign len_in = len_r[s-1];
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    assign dvd = {geo_in.mag, {COS_SHIFT{1'b0}}};
    assign r2  = {rem_in, dvd[I]};

    // restoring step
    always_comb begin
      if (r2 >= {1'b0, len_in}) begin
        rem_nxt = LEN_W'(r2 - {1'b0, len_in});
        quo_nxt = quo_in | (CQ_W'(1) << I);
      end else begin
        rem_nxt = LEN_W'(r2);
        quo_nxt = quo_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[s] <= 1'b0;
      else        vld_r[s] <= vld_in;
    end

    always_ff @(posedge clk) begin
      geo_r[s] <= geo_in;
      len_r[s] <= len_in;
      rem_r[s] <= rem_nxt;
      quo_r[s] <= quo_nxt;
    end
  end

  assign out_vld     = vld_r[CQ_W-1];
  assign out_cos.sum = geo_r[CQ_W-1].sum;
  assign out_cos.neg = geo_r[CQ_W-1].neg;
  assign out_cos.quo = quo_r[CQ_W-1];

endmodule

// ===== rtl/sfi_shape.sv =====
// Penumbra shaping: signed cosine, clamp, pipelined table index divide, shape table.
// Depends on sfi_pkg (types, SHAPE_ROM). 3 + IQ_W register stages.
module sfi_shape (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  sfi_pkg::cos_t                   in_cos,
  input  logic signed [sfi_pkg::CS_W-1:0] cfg_cos_cone,
  input  logic signed [sfi_pkg::CS_W-1:0] cfg_cos_outer,
  output logic                            out_vld,
  output sfi_pkg::shp_t                   out_shp
);
  import sfi_pkg::*;

  logic signed [C_W-1:0] cone_c, outer_c, cl_c, num_c, den_c;
  logic [UD_W-1:0]       un_c, ud_c;

  // stage A: signed cosine
  logic                  vld_a_r;
  logic [SUM_W-1:0]      sum_a_r;
  logic signed [C_W-1:0] c_a_r, c_a_nxt;

  // stage B: clamp and dividend
  logic                  vld_b_r;
  logic [SUM_W-1:0]      sum_b_r;
  logic                  pen_b_r, hard_b_r;
  logic [DVD_W-1:0]      dvd_b_r, dvd_b_nxt;
  logic [UD_W-1:0]       ud_b_r;

  // divider stages
  logic             vld_r  [IQ_W];
  logic [SUM_W-1:0] sum_r  [IQ_W];
  logic             pen_r  [IQ_W];
  logic             hard_r [IQ_W];
  logic [DVD_W-1:0] dvd_r  [IQ_W];
  logic [UD_W-1:0]  ud_r   [IQ_W];
  logic [UD_W-1:0]  rem_r  [IQ_W];
  logic [IQ_W-1:0]  quo_r  [IQ_W];

  // table stage
  logic            vld_t_r;
  shp_t            shp_t_r, shp_t_nxt;
  logic [IQ_W-1:0] idx_c;

  assign c_a_nxt = in_cos.neg ? -C_W'({1'b0, in_cos.quo}) : C_W'({1'b0, in_cos.quo});

  always_comb begin
    cone_c  = C_W'(cfg_cos_cone);
    outer_c = C_W'(cfg_cos_outer);
    if (c_a_r > cone_c)       cl_c = cone_c;
    else if (c_a_r < outer_c) cl_c = outer_c;
    else                      cl_c = c_a_r;
    num_c = cl_c - outer_c;
    den_c = cone_c - outer_c;
    un_c  = num_c[C_W-1] ? UD_W'(-num_c) : UD_W'(num_c);
    ud_c  = den_c[C_W-1] ? UD_W'(-den_c) : UD_W'(den_c);
    dvd_b_nxt = DVD_W'(DVD_W'(un_c) * DVD_W'(SHAPE_DEPTH)) + DVD_W'(ud_c >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    c_a_r    <= c_a_nxt;
    sum_a_r  <= in_cos.sum;
    sum_b_r  <= sum_a_r;
    pen_b_r  <= (cone_c != outer_c);
    hard_b_r <= (c_a_r >= cone_c);
    dvd_b_r  <= dvd_b_nxt;
    ud_b_r   <= ud_c;
  end

  // index divide, one quotient bit per stage
  for (genvar s = 0; s < IQ_W; s++) begin : g_stg
    localparam int I = IQ_W - 1 - s;
    logic             vld_in, pen_in, hard_in;
    logic [SUM_W-1:0] sum_in;
    logic [DVD_W-1:0] dvd_in;
    logic [UD_W-1:0]  ud_in, rem_in, rem_nxt;
    logic [IQ_W-1:0]  quo_in, quo_nxt;
    logic [UD_W:0]    r2;

    if (s == 0) begin : g_head
      assign vld_in  = vld_b_r;
      assign sum_in  = sum_b_r;
      assign pen_in  = pen_b_r;
      assign hard_in = hard_b_r;
      assign dvd_in  = dvd_b_r;
      assign ud_in   = ud_b_r;
      assign rem_in  = UD_W'(dvd_b_r >> IQ_W);
      assign quo_in  = '0;
    end else begin : g_body
      assign vld_in  = vld_r[s-1];
      assign sum_in  = sum_r[s-1];
      assign pen_in  = pen_r[s-1];
      assign hard_in = hard_r[s-1];
      assign dvd_in  = dvd_r[s-1];
      assign ud_in   = ud_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign quo_in  = quo_r[s-1];
    end

    assign r2 = {rem_in, dvd_in[I]};

    always_comb begin
      if (r2 >= {1'b0, ud_in}) begin
        rem_nxt = UD_W'(r2 - {1'b0, ud_in});
        quo_nxt = quo_in | (IQ_W'(1) << I);
      end else begin
        rem_nxt = UD_W'(r2);
        quo_nxt = quo_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[s] <= 1'b0;
      else        vld_r[s] <= vld_in;
    end

    always_ff @(posedge clk) begin
      sum_r[s]  <= sum_in;
      pen_r[s]  <= pen_in;
      hard_r[s] <= hard_in;
      dvd_r[s]  <= dvd_in;
      ud_r[s]   <= ud_in;
      rem_r[s]  <= rem_nxt;
      quo_r[s]  <= quo_nxt;
    end
  end

  // table read, or hard edge without a penumbra
  always_comb begin
    idx_c = (quo_r[IQ_W-1] > IQ_W'(SHAPE_DEPTH)) ? IQ_W'(SHAPE_DEPTH) : quo_r[IQ_W-1];
    shp_t_nxt.sum = sum_r[IQ_W-1];
    if (pen_r[IQ_W-1])       shp_t_nxt.sh = SHAPE_ROM[idx_c];
    else if (hard_r[IQ_W-1]) shp_t_nxt.sh = ONE_Q16;
    else                     shp_t_nxt.sh = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_t_r <= 1'b0;
    else        vld_t_r <= vld_r[IQ_W-1];
  end

  always_ff @(posedge clk) begin
    shp_t_r <= shp_t_nxt;
  end

  assign out_vld = vld_t_r;
  assign out_shp = shp_t_r;

endmodule

// ===== rtl/sfi_scale.sv =====
// Exposure gain and distance falloff: (s << (exposure+16)) / |d|^2 with saturation, or s in constant mode.
// Depends on sfi_pkg. 2 + DQ_W register stages, the last drives the result ports.
module sfi_scale (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  sfi_pkg::shp_t              in_shp,
  input  logic [sfi_pkg::EXP_W-1:0]  cfg_exposure,
  input  logic                       cfg_decay_constant,
  output logic                       out_vld,
  output logic [sfi_pkg::OUT_W-1:0]  out_intensity,
  output logic                       out_saturated,
  output logic                       out_zero_distance
);
  import sfi_pkg::*;

  logic [EXP_W-1:0] amt_c;
  logic [NUM_W-1:0] num_nxt;

  // stage A: shifted numerator and overflow test
  logic             vld_a_r;
  logic [NUM_W-1:0] num_a_r;
  logic [SUM_W-1:0] sum_a_r;
  logic [SH_W-1:0]  sh_a_r;
  logic             ovf_a_r, cmode_a_r, zd_a_r;

  // divider stages
  logic             vld_r   [DQ_W];
  logic [NUM_W-1:0] num_r   [DQ_W];
  logic [SUM_W-1:0] sum_r   [DQ_W];
  logic [SH_W-1:0]  sh_r    [DQ_W];
  logic             ovf_r   [DQ_W];
  logic             cmode_r [DQ_W];
  logic             zd_r    [DQ_W];
  logic [SUM_W-1:0] rem_r   [DQ_W];
  logic [DQ_W-1:0]  quo_r   [DQ_W];

  // output stage
  logic             vld_o_r;
  logic [OUT_W-1:0] int_o_r, int_o_nxt;
  logic             sat_o_r, sat_o_nxt, zd_o_r;

  // exposure + 16, range 0..31
  assign amt_c   = {~cfg_exposure[EXP_W-1], cfg_exposure[EXP_W-2:0]};
  assign num_nxt = NUM_W'(in_shp.sh) << amt_c;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_a_r <= 1'b0;
    else        vld_a_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    num_a_r   <= num_nxt;
    sum_a_r   <= in_shp.sum;
    sh_a_r    <= in_shp.sh;
    ovf_a_r   <= SUM_W'(num_nxt[NUM_W-1:DQ_W]) >= in_shp.sum;
    cmode_a_r <= (cfg_exposure == '0) && cfg_decay_constant;
    zd_a_r    <= (in_shp.sum == '0);
  end

  for (genvar s = 0; s < DQ_W; s++) begin : g_stg
    localparam int I = DQ_W - 1 - s;
    logic             vld_in, ovf_in, cmode_in, zd_in;
    logic [NUM_W-1:0] num_in;
    logic [SUM_W-1:0] sum_in, rem_in, rem_nxt;
    logic [SH_W-1:0]  sh_in;
    logic [DQ_W-1:0]  quo_in, quo_nxt;
    logic [SUM_W:0]   r2;

    if (s == 0) begin : g_head
      assign vld_in   = vld_a_r;
      assign num_in   = num_a_r;
      assign sum_in   = sum_a_r;
      assign sh_in    = sh_a_r;
      assign ovf_in   = ovf_a_r;
      assign cmode_in = cmode_a_r;
      assign zd_in    = zd_a_r;
      assign rem_in   = SUM_W'(num_a_r[NUM_W-1:DQ_W]);
      assign quo_in   = '0;
    end else begin : g_body
      assign vld_in   = vld_r[s-1];
      assign num_in   = num_r[s-1];
      assign sum_in   = sum_r[s-1];
      assign sh_in    = sh_r[s-1];
      assign ovf_in   = ovf_r[s-1];
      assign cmode_in = cmode_r[s-1];
      assign zd_in    = zd_r[s-1];
      assign rem_in   = rem_r[s-1];
      assign quo_in   = quo_r[s-1];
    end

    assign r2 = {rem_in, num_in[I]};

    always_comb begin
      if (r2 >= {1'b0, sum_in}) begin
        rem_nxt = SUM_W'(r2 - {1'b0, sum_in});
        quo_nxt = quo_in | (DQ_W'(1) << I);
      end else begin
        rem_nxt = SUM_W'(r2);
        quo_nxt = quo_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[s] <= 1'b0;
      else        vld_r[s] <= vld_in;
    end

    always_ff @(posedge clk) begin
      num_r[s]   <= num_in;
      sum_r[s]   <= sum_in;
      sh_r[s]    <= sh_in;
      ovf_r[s]   <= ovf_in;
      cmode_r[s] <= cmode_in;
      zd_r[s]    <= zd_in;
      rem_r[s]   <= rem_nxt;
      quo_r[s]   <= quo_nxt;
    end
  end

  // result select: zero distance, constant mode, saturation, quotient
  always_comb begin
    if (zd_r[DQ_W-1]) begin
      int_o_nxt = '0;
      sat_o_nxt = 1'b0;
    end else if (cmode_r[DQ_W-1]) begin
      int_o_nxt = OUT_W'(sh_r[DQ_W-1]);
      sat_o_nxt = 1'b0;
    end else if (ovf_r[DQ_W-1]) begin
      int_o_nxt = '1;
      sat_o_nxt = 1'b1;
    end else begin
      int_o_nxt = quo_r[DQ_W-1];
      sat_o_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_o_r <= 1'b0;
    else        vld_o_r <= vld_r[DQ_W-1];
  end

  always_ff @(posedge clk) begin
    int_o_r <= int_o_nxt;
    sat_o_r <= sat_o_nxt;
    zd_o_r  <= zd_r[DQ_W-1];
  end

  assign out_vld           = vld_o_r;
  assign out_intensity     = int_o_r;
  assign out_saturated     = sat_o_r;
  assign out_zero_distance = zd_o_r;

endmodule

// ===== rtl/sfi_checker.sv =====
// Port-level checks for the spotlight unit, attached by bind.
// Depends on sfi_pkg (LATENCY) and spotlight_falloff_intensity_unit_defines.svh.
`include "spotlight_falloff_intensity_unit_defines.svh"

module sfi_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [sfi_pkg::OUT_W-1:0] out_intensity,
  input logic                      out_saturated,
  input logic                      out_zero_distance
);
  import sfi_pkg::*;

  // every accepted beat gives a strobe after the fixed latency
  `SFI_ASSERT_DLY(a_beat_out, start && !busy, LATENCY, out_valid, "accepted beat gave no result")

  // no strobe without a beat accepted one latency earlier
  `SFI_ASSERT_IMP(a_no_orphan, out_valid, $past(start && !busy, LATENCY), "result without beat")

  // zero distance forces a clean zero result
  `SFI_ASSERT_IMP(a_zero_dist, out_valid && out_zero_distance,
                  out_intensity == '0 && !out_saturated, "zero distance result not zero")

  // saturation means all ones and a nonzero distance
  `SFI_ASSERT_IMP(a_sat_max, out_valid && out_saturated,
                  out_intensity == '1 && !out_zero_distance, "saturated result not at maximum")

endmodule

bind spotlight_falloff_intensity_unit sfi_checker u_sfi_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_intensity     (out_intensity),
  .out_saturated     (out_saturated),
  .out_zero_distance (out_zero_distance)
);
